// ===== hdl/mbrtu_pkg.sv =====
// shared constants, types and crc helper for the modbus rtu slave
`default_nettype none
package mbrtu_pkg;

  localparam int unsigned NumHoldingRegs = 16;
  localparam int unsigned NumInputRegs   = 16;
  localparam int unsigned MaxReadWords   = 16;

  localparam logic [15:0] CoilOn  = 16'hFF00;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam int unsigned HeadBytes   = 8;
  localparam int unsigned EchoLen     = 8;
  localparam int unsigned CoilRespLen = 7;
  localparam int unsigned ReadHdrLen  = 3;
  localparam int unsigned NumCoilAddr = 4;

  localparam logic [7:0] FnReadCoils   = 8'd1;
  localparam logic [7:0] FnReadHolding = 8'd3;
  localparam logic [7:0] FnReadInput   = 8'd4;
  localparam logic [7:0] FnWriteCoil   = 8'd5;
  localparam logic [7:0] FnWriteReg    = 8'd6;

  localparam int unsigned RegSlaveId   = 0;
  localparam logic [7:0]  SlaveIdReset = 8'd1;

  typedef enum logic [1:0] {
    KindCoils = 2'd0,
    KindRead  = 2'd1,
    KindEcho  = 2'd2
  } kind_e;

  // head bytes of the last frame and its crc/address verdict
  typedef struct packed {
    logic [HeadBytes-1:0][7:0] head;
    logic                      ok;
  } frame_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/mbrtu_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module mbrtu_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mbrtu_rx.sv =====
// request receiver: head bytes, byte count and running crc of the frame
`default_nettype none
module mbrtu_rx (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             beat_i,
  input  wire logic [7:0]       rx_byte_i,
  input  wire logic             frame_end_i,
  input  wire logic [7:0]       slave_id_i,
  output mbrtu_pkg::frame_t     frame_o
);
  import mbrtu_pkg::*;

  logic [HeadBytes-1:0][7:0] head_q;
  logic [8:0]                cnt_q, cnt_d;
  logic [15:0]               crc_q, crc_d, crc_nx;
  logic                      ok_q, ok_d;
  logic [7:0]                head0_nx;

  assign crc_nx   = crc_byte(crc_q, rx_byte_i);
  assign head0_nx = (cnt_q == 9'd0) ? rx_byte_i : head_q[0];

  always_comb begin
    cnt_d = cnt_q;
    crc_d = crc_q;
    ok_d  = ok_q;
    if (beat_i) begin
      ok_d  = (crc_nx == 16'h0000) && (head0_nx == slave_id_i);
      if (frame_end_i) begin
        cnt_d = '0;
        crc_d = CrcInit;
      end else begin
        crc_d = crc_nx;
        if (cnt_q != 9'h1FF) begin
          cnt_d = cnt_q + 9'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      crc_q <= CrcInit;
      ok_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      crc_q <= crc_d;
      ok_q  <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_i && (cnt_q < 9'(HeadBytes))) begin
      head_q[cnt_q[2:0]] <= rx_byte_i;
    end
  end

  assign frame_o.head = head_q;
  assign frame_o.ok   = ok_q;

endmodule
`default_nettype wire

// ===== hdl/modbus_rtu_slave_frame_handler.sv =====
// top level: apb register, request executor and response sequencer
`default_nettype none
// Modbus RTU slave. Request bytes arrive one per beat on the input channel; an
// input register load uses mode 1. The beat that ends a frame is followed by a
// check state, then the response goes out one byte per cycle while the output
// side does not stall. Register reads (functions 3 and 4) add a fetch state per
// register for the single read port of the register ram, and each fetch pauses
// the byte stream. The input is stalled from the frame end until the last
// response byte has been loaded into the output register, or until the check
// ends if no response is sent. Holding and input registers live in rams with
// per-entry valid bits; an entry never written reads as zero. Slave id is the
// only apb register, at address 0, reset 1.
module modbus_rtu_slave_frame_handler #(
  parameter int unsigned NUM_HOLDING_REGS = mbrtu_pkg::NumHoldingRegs,
  parameter int unsigned NUM_INPUT_REGS   = mbrtu_pkg::NumInputRegs,
  parameter int unsigned MAX_READ_WORDS   = mbrtu_pkg::MaxReadWords
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        frame_end_i,
  input  wire logic [3:0]  load_index_i,
  input  wire logic [15:0] load_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [7:0]  tx_byte_o,
  output logic             tx_last_o,
  output logic      [15:0] coil_state_o
);
  import mbrtu_pkg::*;

  localparam int unsigned HAw     = (NUM_HOLDING_REGS > 1) ? $clog2(NUM_HOLDING_REGS) : 1;
  localparam int unsigned IAw     = (NUM_INPUT_REGS > 1) ? $clog2(NUM_INPUT_REGS) : 1;
  localparam int unsigned MaxAw   = (HAw > IAw) ? HAw : IAw;
  localparam int unsigned RespMax = 5 + 2 * MAX_READ_WORDS;
  localparam int unsigned PosW    = $clog2(RespMax + 1);
  localparam int unsigned RiW     = $clog2(MAX_READ_WORDS + 1);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StCheck = 4'b0010,
    StSend  = 4'b0100,
    StFetch = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [7:0]        slave_id_q;
  logic [15:0]       coil_q, coil_d;
  kind_e             kind_q, kind_d;
  logic [PosW-1:0]   len_q, len_d, pos_q, pos_d;
  logic [RiW-1:0]    ri_q, ri_d;
  logic [MaxAw-1:0]  base_q, base_d;
  logic              is_hold_q, is_hold_d;
  logic              have_word_q, have_word_d;
  logic              rvld_q, rvld_d;
  logic [15:0]       tcrc_q, tcrc_d;
  logic [7:0]        qty2_q, qty2_d;
  logic [NUM_HOLDING_REGS-1:0] hvld_q, hvld_d;
  logic [NUM_INPUT_REGS-1:0]   ivld_q, ivld_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        tx_byte_q, tx_byte_d;
  logic              tx_last_q, tx_last_d;
  logic [15:0]       coil_out_q, coil_out_d;

  frame_t            frame;
  logic              in_acc, rx_beat, load_beat, apb_wr;
  logic [7:0]        fn;
  logic [15:0]       addr16, word16, rd_addr16, word;
  logic [16:0]       rd_limit;
  logic              rd_bad;
  logic              h_we, h_re, i_we, i_re;
  logic [HAw-1:0]    h_waddr, h_raddr;
  logic [IAw-1:0]    i_waddr, i_raddr;
  logic [15:0]       h_rdata, i_rdata;
  logic              slot, sealed, crc_zone, data_zone, need_fetch, emit, is_last;
  logic [7:0]        byte_sel;

  // apb register
  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite;
  assign prdata = (paddr[2:2] == 1'(RegSlaveId)) ? {24'h0, slave_id_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_id_q <= SlaveIdReset;
    end else if (apb_wr && (paddr[2:2] == 1'(RegSlaveId))) begin
      slave_id_q <= pwdata[7:0];
    end
  end

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign rx_beat    = in_acc && !mode_i;
  assign load_beat  = in_acc && mode_i && (32'(load_index_i) < NUM_INPUT_REGS);

  mbrtu_rx u_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (rx_beat),
    .rx_byte_i   (rx_byte_i),
    .frame_end_i (frame_end_i),
    .slave_id_i  (slave_id_q),
    .frame_o     (frame)
  );

  assign fn       = frame.head[1];
  assign addr16   = {frame.head[2], frame.head[3]};
  assign word16   = {frame.head[4], frame.head[5]};
  assign rd_limit = (fn == FnReadHolding) ? 17'(NUM_HOLDING_REGS) : 17'(NUM_INPUT_REGS);
  assign rd_bad   = (word16 == 16'h0) || (word16 > 16'(MAX_READ_WORDS)) ||
                    (({1'b0, addr16} + {1'b0, word16}) > rd_limit);

  // register rams
  assign rd_addr16 = 16'(base_q) + 16'(ri_q);
  assign h_waddr   = addr16[HAw-1:0];
  assign h_raddr   = rd_addr16[HAw-1:0];
  assign i_waddr   = IAw'(load_index_i);
  assign i_raddr   = rd_addr16[IAw-1:0];
  assign h_we      = (state_q == StCheck) && frame.ok && (fn == FnWriteReg) &&
                     (addr16 < 16'(NUM_HOLDING_REGS));
  assign i_we      = load_beat;
  assign h_re      = (state_q == StFetch) && is_hold_q;
  assign i_re      = (state_q == StFetch) && !is_hold_q;

  mbrtu_ram #(.Width(16), .Depth(NUM_HOLDING_REGS)) u_hold_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (word16),
    .re_i    (h_re),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  mbrtu_ram #(.Width(16), .Depth(NUM_INPUT_REGS)) u_input_ram (
    .clk_i   (clk_i),
    .we_i    (i_we),
    .waddr_i (i_waddr),
    .wdata_i (load_value_i),
    .re_i    (i_re),
    .raddr_i (i_raddr),
    .rdata_o (i_rdata)
  );

  assign word = rvld_q ? (is_hold_q ? h_rdata : i_rdata) : 16'h0;

  // response byte selection
  assign slot       = !out_valid_q || !out_stall_i;
  assign sealed     = (kind_q != KindEcho);
  assign crc_zone   = sealed && (pos_q >= (len_q - PosW'(2)));
  assign data_zone  = (kind_q == KindRead) && (pos_q >= PosW'(ReadHdrLen)) && !crc_zone;
  // odd positions carry the high byte of a register
  assign need_fetch = data_zone && pos_q[0] && !have_word_q;
  assign emit       = (state_q == StSend) && slot && !need_fetch;
  assign is_last    = (pos_q == (len_q - PosW'(1)));

  always_comb begin
    byte_sel = 8'h00;
    if (kind_q == KindEcho) begin
      byte_sel = frame.head[pos_q[2:0]];
    end else if (crc_zone) begin
      byte_sel = is_last ? tcrc_q[15:8] : tcrc_q[7:0];
    end else if (pos_q == PosW'(0)) begin
      byte_sel = frame.head[0];
    end else if (pos_q == PosW'(1)) begin
      byte_sel = frame.head[1];
    end else if (pos_q == PosW'(2)) begin
      byte_sel = (kind_q == KindCoils) ? 8'd2 : qty2_q;
    end else if (kind_q == KindCoils) begin
      byte_sel = (pos_q == PosW'(3)) ? coil_q[7:0] : coil_q[15:8];
    end else begin
      byte_sel = pos_q[0] ? word[15:8] : word[7:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    coil_d      = coil_q;
    kind_d      = kind_q;
    len_d       = len_q;
    pos_d       = pos_q;
    ri_d        = ri_q;
    base_d      = base_q;
    is_hold_d   = is_hold_q;
    have_word_d = have_word_q;
    rvld_d      = rvld_q;
    tcrc_d      = tcrc_q;
    qty2_d      = qty2_q;
    hvld_d      = hvld_q;
    ivld_d      = ivld_q;
    out_valid_d = out_valid_q;
    tx_byte_d   = tx_byte_q;
    tx_last_d   = tx_last_q;
    coil_out_d  = coil_out_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (load_beat) begin
      ivld_d[i_waddr] = 1'b1;
    end
    if (h_we) begin
      hvld_d[h_waddr] = 1'b1;
    end

    unique case (state_q)
      StIdle: begin
        if (rx_beat && frame_end_i) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        state_d     = StIdle;
        pos_d       = '0;
        ri_d        = '0;
        have_word_d = 1'b0;
        tcrc_d      = CrcInit;
        base_d      = addr16[MaxAw-1:0];
        is_hold_d   = (fn == FnReadHolding);
        qty2_d      = {word16[6:0], 1'b0};
        if (frame.ok) begin
          if (fn == FnReadCoils) begin
            kind_d  = KindCoils;
            len_d   = PosW'(CoilRespLen);
            state_d = StSend;
          end else if ((fn == FnReadHolding) || (fn == FnReadInput)) begin
            if (!rd_bad) begin
              kind_d  = KindRead;
              // header, two bytes per register, two crc bytes
              len_d   = PosW'(32'(ReadHdrLen) + 32'(word16) * 2 + 2);
              state_d = StSend;
            end
          end else if (fn == FnWriteCoil) begin
            if (addr16 < 16'(NumCoilAddr)) begin
              if (word16 == CoilOn) begin
                coil_d = coil_q | (16'h1 << addr16[1:0]);
              end else begin
                coil_d = coil_q & ~(16'h1 << addr16[1:0]);
              end
            end
            kind_d  = KindEcho;
            len_d   = PosW'(EchoLen);
            state_d = StSend;
          end else if (fn == FnWriteReg) begin
            if (addr16 < 16'(NUM_HOLDING_REGS)) begin
              kind_d  = KindEcho;
              len_d   = PosW'(EchoLen);
              state_d = StSend;
            end
          end
        end
      end
      StSend: begin
        if (need_fetch) begin
          state_d = StFetch;
        end else if (emit) begin
          out_valid_d = 1'b1;
          tx_byte_d   = byte_sel;
          tx_last_d   = is_last;
          coil_out_d  = coil_q;
          pos_d       = pos_q + PosW'(1);
          if (sealed && !crc_zone) begin
            tcrc_d = crc_byte(tcrc_q, byte_sel);
          end
          if (data_zone && !pos_q[0]) begin
            have_word_d = 1'b0;
            ri_d        = ri_q + RiW'(1);
          end
          if (is_last) begin
            state_d = StIdle;
          end
        end
      end
      StFetch: begin
        rvld_d      = is_hold_q ? hvld_q[h_raddr] : ivld_q[i_raddr];
        have_word_d = 1'b1;
        state_d     = StSend;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      coil_q      <= '0;
      kind_q      <= KindEcho;
      len_q       <= '0;
      pos_q       <= '0;
      ri_q        <= '0;
      base_q      <= '0;
      is_hold_q   <= 1'b0;
      have_word_q <= 1'b0;
      rvld_q      <= 1'b0;
      tcrc_q      <= CrcInit;
      qty2_q      <= '0;
      hvld_q      <= '0;
      ivld_q      <= '0;
      out_valid_q <= 1'b0;
      tx_byte_q   <= '0;
      tx_last_q   <= 1'b0;
      coil_out_q  <= '0;
    end else begin
      state_q     <= state_d;
      coil_q      <= coil_d;
      kind_q      <= kind_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      ri_q        <= ri_d;
      base_q      <= base_d;
      is_hold_q   <= is_hold_d;
      have_word_q <= have_word_d;
      rvld_q      <= rvld_d;
      tcrc_q      <= tcrc_d;
      qty2_q      <= qty2_d;
      hvld_q      <= hvld_d;
      ivld_q      <= ivld_d;
      out_valid_q <= out_valid_d;
      tx_byte_q   <= tx_byte_d;
      tx_last_q   <= tx_last_d;
      coil_out_q  <= coil_out_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tx_byte_o    = tx_byte_q;
  assign tx_last_o    = tx_last_q;
  assign coil_state_o = coil_out_q;

endmodule
`default_nettype wire

// ===== hdl/mbrtu_chk.sv =====
// port-level checker for the modbus rtu slave, bound to the top level
`default_nettype none
module mbrtu_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        mode_i,
  input wire logic        frame_end_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [7:0]  tx_byte_o,
  input wire logic        tx_last_o,
  input wire logic [15:0] coil_state_o
);

  // a stalled response beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tx_byte_o) &&
    $stable(tx_last_o) && $stable(coil_state_o))
    else $error("stalled response beat changed");

  // no request beat is taken while a response is still being sent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tx_last_o |-> in_stall_o)
    else $error("input taken in the middle of a response");

  // a frame byte without frame end leaves the block ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !mode_i && !frame_end_i |=> !in_stall_o)
    else $error("busy after a plain frame byte");

  // an input register load leaves the block ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && mode_i |=> !in_stall_o)
    else $error("busy after a register load");

endmodule

bind modbus_rtu_slave_frame_handler mbrtu_chk u_mbrtu_chk (.*);
`default_nettype wire
